// ----- design/wdw_pkg.sv -----
// Shared types and constants for the weighted draw block.
`timescale 1ns / 1ps

package wdw_pkg;

    // Fixed field widths of the channels and the register port
    localparam int REG_COUNT = 6;
    localparam int WEIGHT_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int RAND_W    = 16;
    localparam int KIND_W    = 3;
    localparam int DIV_CNT_W = $clog2(RAND_W);

    // Opcodes of an input item
    localparam logic OP_RELOAD = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } wdw_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic reload;
        logic sum;
        logic set_exhausted;
        logic pick_direct;
        logic div_step;
        logic scan_step;
        logic out_load;
    } wdw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_draw;
        logic total_zero;
        logic rnd_below_total;
        logic div_last;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } wdw_status_t;

endpackage

// ----- design/wdw_in_if.sv -----
// Request channel: opcode and raw random value with valid/ready.
`timescale 1ns / 1ps

interface wdw_in_if;
    import wdw_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [RAND_W-1:0] random_value;

    modport source (output valid, output opcode, output random_value, input ready);
    modport sink   (input valid, input opcode, input random_value, output ready);
endinterface

// ----- design/wdw_out_if.sv -----
// Response channel: chosen kind and exhausted flag with valid/ready.
`timescale 1ns / 1ps

interface wdw_out_if;
    import wdw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] chosen_kind;
    logic              exhausted;

    modport source (output valid, output chosen_kind, output exhausted, input ready);
    modport sink   (input valid, input chosen_kind, input exhausted, output ready);
endinterface

// ----- design/wdw_datapath.sv -----
// Datapath: weights, remaining counts, sum, serial modulo, prefix scan, output register.
`timescale 1ns / 1ps

module wdw_datapath #(
    parameter int NUM_KINDS  = 6,
    parameter int COUNT_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wdw_pkg::wdw_cmd_t              cmd,
    output wdw_pkg::wdw_status_t           status,
    input  logic                           opcode,
    input  logic [wdw_pkg::RAND_W-1:0]     random_value,
    input  logic                           write_en,
    input  logic [wdw_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [wdw_pkg::WEIGHT_W-1:0]   write_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wdw_pkg::KIND_W-1:0]     chosen_kind,
    output logic                           exhausted
);
    import wdw_pkg::*;

    localparam int IDX_W   = $clog2(NUM_KINDS);
    localparam int TOTAL_W = COUNT_BITS + $clog2(NUM_KINDS);
    localparam int CMP_W   = (TOTAL_W > RAND_W) ? TOTAL_W : RAND_W;
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_KINDS - 1);
    localparam logic [DIV_CNT_W-1:0] LAST_BIT = DIV_CNT_W'(RAND_W - 1);

    logic [WEIGHT_W-1:0]   weight_reg [REG_COUNT];
    logic [COUNT_BITS-1:0] count_reg  [NUM_KINDS];
    logic [COUNT_BITS-1:0] reload_val [NUM_KINDS];

    logic                  op_reg;
    logic [RAND_W-1:0]     rnd_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [TOTAL_W-1:0]    rem_reg;
    logic [TOTAL_W-1:0]    rem_next;
    logic [TOTAL_W:0]      trial;
    logic [TOTAL_W-1:0]    prefix_reg;
    logic [TOTAL_W-1:0]    prefix_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [DIV_CNT_W-1:0]  bit_cnt_reg;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  scan_hit;
    logic [KIND_W-1:0]     res_kind_reg;
    logic                  res_exh_reg;
    logic                  out_valid_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic                  out_exh_reg;

    // Write weight registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                weight_reg[i] <= '0;
            end
        end
        else if (write_en && (write_index < CFG_IDX_W'(REG_COUNT)))
        begin
            weight_reg[write_index] <= write_data;
        end
    end

    // Reload values: weight masked or widened to the count width, zero for kinds without a register
    for (genvar g = 0; g < NUM_KINDS; g++)
    begin : g_reload
        if (g < REG_COUNT)
        begin : g_weighted
            logic [COUNT_BITS+WEIGHT_W-1:0] wide;
            assign wide          = {{COUNT_BITS{1'b0}}, weight_reg[g]};
            assign reload_val[g] = wide[COUNT_BITS-1:0];
        end
        else
        begin : g_unweighted
            assign reload_val[g] = '0;
        end
    end

    // Total of the remaining counts
    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            total_next = total_next + TOTAL_W'(count_reg[k]);
        end
    end

    // One restoring step of the modulo: shift in the next random bit, subtract if it fits
    assign trial    = {rem_reg, rnd_reg[RAND_W-1]};
    assign rem_next = (trial >= {1'b0, total_reg}) ? TOTAL_W'(trial - {1'b0, total_reg})
                                                   : trial[TOTAL_W-1:0];

    // Prefix scan over the kinds, one kind a cycle
    assign cur_count   = count_reg[idx_reg];
    assign prefix_next = prefix_reg + TOTAL_W'(cur_count);
    assign scan_hit    = (cur_count != '0) && (rem_reg < prefix_next);

    // Remaining counts: reload from weights or take one ticket on a hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (cmd.reload)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                count_reg[k] <= reload_val[k];
            end
        end
        else if (cmd.scan_step && scan_hit)
        begin
            count_reg[idx_reg] <= cur_count - 1'b1;
        end
    end

    // Working registers of one item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            rnd_reg      <= random_value;
            rem_reg      <= '0;
            prefix_reg   <= '0;
            idx_reg      <= '0;
            bit_cnt_reg  <= '0;
            res_kind_reg <= '0;
            res_exh_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.sum)
            begin
                total_reg <= total_next;
            end
            if (cmd.set_exhausted)
            begin
                res_exh_reg <= 1'b1;
            end
            if (cmd.pick_direct)
            begin
                rem_reg <= TOTAL_W'(rnd_reg);
            end
            if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                rnd_reg     <= rnd_reg << 1;
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                prefix_reg <= prefix_next;
                idx_reg    <= idx_reg + 1'b1;
                if (scan_hit)
                begin
                    res_kind_reg <= KIND_W'(idx_reg);
                end
            end
        end
    end

    // Output register: a new result may load while the old one transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_exh_reg  <= res_exh_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chosen_kind = out_kind_reg;
    assign exhausted   = out_exh_reg;

    // Status to the controller
    always_comb
    begin
        status                 = '0;
        status.op_draw         = (op_reg == OP_DRAW);
        status.total_zero      = (total_reg == '0);
        status.rnd_below_total = (CMP_W'(rnd_reg) < CMP_W'(total_reg));
        status.div_last        = (bit_cnt_reg == LAST_BIT);
        status.scan_hit        = scan_hit;
        status.scan_last       = (idx_reg == LAST_IDX);
        status.out_free        = !out_valid_reg || out_ready;
    end

endmodule

// ----- design/wdw_ctrl.sv -----
// Controller: sequences capture, sum, modulo, scan and result hand-off.
`timescale 1ns / 1ps

module wdw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output wdw_pkg::wdw_cmd_t    cmd,
    input  wdw_pkg::wdw_status_t status
);
    import wdw_pkg::*;

    wdw_state_t state_reg;
    wdw_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.op_draw)
                begin
                    cmd.sum    = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.reload = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_CHECK:
            begin
                if (status.total_zero)
                begin
                    cmd.set_exhausted = 1'b1;
                    state_next        = ST_DONE;
                end
                else if (status.rnd_below_total)
                begin
                    cmd.pick_direct = 1'b1;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit || status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/weighted_draw_without_replacement.sv -----
// Weighted draw without replacement: top level joining controller and datapath.
// Sequence: a reload passes EXEC and DONE from transfer in to result valid; a draw with nothing
// left passes EXEC, CHECK and DONE; a draw below the total passes EXEC, CHECK, one SCAN state per
// kind scanned up to the hit, then DONE; otherwise the 16-step serial modulo in DIV precedes SCAN.
// Flow: one item at a time; DONE waits for a free output, next transfer in the cycle after the load.
// Reset: counts and weights clear to zero, controller idles, output register empty.
`timescale 1ns / 1ps

module weighted_draw_without_replacement #(
    parameter int NUM_KINDS  = 6,
    parameter int COUNT_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wdw_in_if.sink                        req,
    wdw_out_if.source                     rsp,
    input  logic                          write_en,
    input  logic [wdw_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [wdw_pkg::WEIGHT_W-1:0]  write_data
);
    import wdw_pkg::*;

    wdw_cmd_t    cmd;
    wdw_status_t status;

    // Sequencer
    wdw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Storage and arithmetic
    wdw_datapath #(
        .NUM_KINDS  (NUM_KINDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (req.opcode),
        .random_value (req.random_value),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .chosen_kind  (rsp.chosen_kind),
        .exhausted    (rsp.exhausted)
    );

endmodule
